[design/kfsit_pkg.sv]
// shared types and constants of the keyframe seek index table
`timescale 1ns / 1ps
`default_nettype none
package kfsit_pkg;

   localparam int MAX_ENTRIES = 256;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // ordering key, timestamp in the top bits so a plain compare is lexicographic
   typedef struct packed {
      logic [63:0] ts;
      logic [31:0] chunk;
      logic [63:0] offset;
   } sort_key_type;

   typedef struct packed {
      sort_key_type k;
      logic         key;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic enable;
   } scan_ctl_type;

   typedef struct packed {
      logic [63:0] offset;
      logic        chunk_hit;
   } scan_result_type;

endpackage
`default_nettype wire

[design/kfsit_table.sv]
// entry storage: one write port, one read port with registered read data
`timescale 1ns / 1ps
`default_nettype none
module kfsit_table (
   input  wire                         clock,
   input  wire                         wr_en,
   input  wire [kfsit_pkg::IDX_W-1:0]  wr_addr,
   input  kfsit_pkg::entry_type        wr_data,
   input  wire                         rd_en,
   input  wire [kfsit_pkg::IDX_W-1:0]  rd_addr,
   output kfsit_pkg::entry_type        rd_data
);

   kfsit_pkg::entry_type mem [kfsit_pkg::MAX_ENTRIES];
   kfsit_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[design/kfsit_scan.sv]
// running minimum, best match at or below query time, and chunk hit over a scan
`timescale 1ns / 1ps
`default_nettype none
module kfsit_scan (
   input  wire                        clock,
   input  wire                        reset,
   input  kfsit_pkg::scan_ctl_type    ctl,
   input  kfsit_pkg::entry_type       entry,
   input  wire [63:0]                 qtime,
   input  wire [31:0]                 chunk,
   output kfsit_pkg::scan_result_type res
);

   logic                    have_min_ff, have_min_in;
   logic                    have_best_ff, have_best_in;
   logic                    hit_ff, hit_in;
   kfsit_pkg::sort_key_type min_ff, min_in;
   kfsit_pkg::sort_key_type best_ff, best_in;

   always_comb begin
      have_min_in  = have_min_ff;
      have_best_in = have_best_ff;
      hit_in       = hit_ff;
      min_in       = min_ff;
      best_in      = best_ff;
      if (ctl.clear) begin
         have_min_in  = 1'b0;
         have_best_in = 1'b0;
         hit_in       = 1'b0;
      end else if (ctl.enable) begin
         if (entry.key && (!have_min_ff || (entry.k < min_ff))) begin
            have_min_in = 1'b1;
            min_in      = entry.k;
         end
         if (entry.key && (entry.k.ts <= qtime) &&
             (!have_best_ff || (best_ff < entry.k))) begin
            have_best_in = 1'b1;
            best_in      = entry.k;
         end
         if (entry.k.chunk == chunk) begin
            hit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_min_ff  <= 1'b0;
         have_best_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         have_min_ff  <= have_min_in;
         have_best_ff <= have_best_in;
         hit_ff       <= hit_in;
      end
      min_ff  <= min_in;
      best_ff <= best_in;
   end

   always_comb begin
      if (have_best_ff) begin
         res.offset = best_ff.offset;
      end else if (have_min_ff) begin
         res.offset = min_ff.offset;
      end else begin
         res.offset = 64'd0;
      end
      res.chunk_hit = hit_ff;
   end

endmodule
`default_nettype wire

[design/keyframe_seek_index_table.sv]
// top level of the keyframe seek index table: control, entry count, result register
//
// req channel carries one command item: an add stores a packet entry, a query
// asks for the offset of the nearest keyframe at or below the given time.
// rsp channel returns exactly one item per command, in order.
// every command but an add dropped on a full table walks the stored
// entries through the table's single read port, one entry per cycle;
// the table holds up to 256 entries.
// one command is in work at a time; req_tready is high only while idle.
// the finished item sits in an output register, so the next command can be
// taken while the previous result still waits for rsp_tready; a command that
// completes while that register is still full waits until it is taken.
// an add updates the table only when its result is loaded for delivery.
// reset empties the table (entry count to zero) and drops any pending result;
// the storage itself is not cleared, entries beyond the count are never read.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_seek_index_table (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire [159:0]  req_tdata,   // timestamp[63:0], chunk_number[95:64], byte_offset[159:96]
   input  wire [1:0]    req_tuser,   // cmd[0], is_key[1]
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [63:0]  rsp_tdata,   // seek_offset[63:0]
   output logic [1:0]   rsp_tuser    // stored_as_key[0], dropped[1]
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic [kfsit_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [kfsit_pkg::CNT_W-1:0]   issue_ff, issue_in;
   logic                          rd_vld_ff, rd_vld_in;

   logic                          cmd_ff, cmd_in;
   logic [63:0]                   ts_ff, ts_in;
   logic [31:0]                   chunk_ff, chunk_in;
   logic [63:0]                   offs_ff, offs_in;
   logic                          key_ff, key_in;
   logic                          drop_ff, drop_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [63:0]                   rsp_data_ff, rsp_data_in;
   logic                          rsp_key_ff, rsp_key_in;
   logic                          rsp_drop_ff, rsp_drop_in;

   logic                          rd_en;
   logic                          wr_en;
   logic                          new_key;
   kfsit_pkg::entry_type          wr_data;
   kfsit_pkg::entry_type          rd_data;
   kfsit_pkg::scan_ctl_type       scan_ctl;
   kfsit_pkg::scan_result_type    scan_res;

   kfsit_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[kfsit_pkg::IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[kfsit_pkg::IDX_W-1:0]),
      .rd_data (rd_data)
   );

   kfsit_scan u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .entry (rd_data),
      .qtime (ts_ff),
      .chunk (chunk_ff),
      .res   (scan_res)
   );

   // new entry is a keyframe if flagged or if its chunk was not seen before
   assign new_key       = key_ff || !scan_res.chunk_hit;
   assign wr_data.k.ts     = ts_ff;
   assign wr_data.k.chunk  = chunk_ff;
   assign wr_data.k.offset = offs_ff;
   assign wr_data.key      = new_key;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      rd_vld_in    = 1'b0;
      cmd_in       = cmd_ff;
      ts_in        = ts_ff;
      chunk_in     = chunk_ff;
      offs_in      = offs_ff;
      key_in       = key_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_drop_in  = rsp_drop_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      scan_ctl.clear  = 1'b0;
      scan_ctl.enable = rd_vld_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in         = req_tuser[0];
               key_in         = req_tuser[1];
               ts_in          = req_tdata[63:0];
               chunk_in       = req_tdata[95:64];
               offs_in        = req_tdata[159:96];
               issue_in       = '0;
               scan_ctl.clear = 1'b1;
               if ((req_tuser[0] == kfsit_pkg::CMD_ADD) &&
                   (count_ff == kfsit_pkg::CNT_W'(kfsit_pkg::MAX_ENTRIES))) begin
                  drop_in  = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  drop_in  = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               issue_in  = issue_ff + kfsit_pkg::CNT_W'(1);
            end else if (!rd_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (cmd_ff == kfsit_pkg::CMD_QUERY) begin
                  rsp_data_in = scan_res.offset;
                  rsp_key_in  = 1'b0;
                  rsp_drop_in = 1'b0;
               end else begin
                  rsp_data_in = 64'd0;
                  rsp_key_in  = !drop_ff && new_key;
                  rsp_drop_in = drop_ff;
                  if (!drop_ff) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + kfsit_pkg::CNT_W'(1);
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      ts_ff       <= ts_in;
      chunk_ff    <= chunk_in;
      offs_ff     <= offs_in;
      key_ff      <= key_in;
      drop_ff     <= drop_in;
      rsp_data_ff <= rsp_data_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_drop_ff, rsp_key_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= kfsit_pkg::CNT_W'(kfsit_pkg::MAX_ENTRIES))
      else $error("entry count beyond table size");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_SCAN))
      else $error("read data returned outside a scan");

   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_drop_ff) |->
         (count_ff == kfsit_pkg::CNT_W'(kfsit_pkg::MAX_ENTRIES)))
      else $error("add dropped while table not full");

   a_drop_not_key: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> !(rsp_valid_ff && rsp_drop_ff && rsp_key_ff))
      else $error("dropped add reported as stored keyframe");

endmodule
`default_nettype wire
